/* rtl/core/dtc_pkg.sv */
package dtc_pkg;

  localparam int RATE_W  = 36;
  localparam int WORD_W  = 64;
  localparam int COUNT_W = 32;

  localparam logic [RATE_W-1:0]  NS_RATE   = 36'd1000000000;
  localparam logic [WORD_W-1:0]  COUNT_MAX = 64'h0000_0000_ffff_ffff;

  // shared unit step counts
  localparam int DIV_STEPS = WORD_W;
  localparam int MUL_STEPS = RATE_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic OP_DIV = 1'b0;
  localparam logic OP_MUL = 1'b1;

  localparam logic [1:0] MODE_ARM    = 2'd0;
  localparam logic [1:0] MODE_DISARM = 2'd1;
  localparam logic [1:0] MODE_EXPIRE = 2'd2;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_LOAD = 2'd1;
  localparam logic [1:0] ACT_STOP = 2'd2;

  localparam logic [1:0] REG_STAMP_RATE     = 2'd0;
  localparam logic [1:0] REG_COUNTDOWN_RATE = 2'd1;

  typedef struct packed {
    logic start;
    logic op;
  } dtc_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dtc_sts_t;

endpackage

/* rtl/core/dtc_unit.sv */
// Shared shift/add unit: 64/36 restoring divide, one quotient bit per cycle,
// or 64x36 multiply mod 2^64, one multiplier bit per cycle.
module dtc_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  dtc_pkg::dtc_cmd_t             cmd,
  input  logic [dtc_pkg::WORD_W-1:0]    a,
  input  logic [dtc_pkg::RATE_W-1:0]    b,
  output dtc_pkg::dtc_sts_t             sts,
  output logic [dtc_pkg::WORD_W-1:0]    res,
  output logic [dtc_pkg::RATE_W-1:0]    rmd
);

  logic                          busy;
  logic                          done;
  logic                          op;
  logic [dtc_pkg::STEP_W-1:0]    cnt;
  logic [dtc_pkg::WORD_W-1:0]    acc;
  logic [dtc_pkg::WORD_W-1:0]    work;
  logic [dtc_pkg::RATE_W:0]      rem;
  logic [dtc_pkg::RATE_W-1:0]    dvs;

  logic [dtc_pkg::RATE_W:0]      trial;
  logic                          ge;

  assign trial = {rem[dtc_pkg::RATE_W-1:0], work[dtc_pkg::WORD_W-1]};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        op   <= cmd.op;
        cnt  <= (cmd.op == dtc_pkg::OP_DIV) ? dtc_pkg::STEP_W'(dtc_pkg::DIV_STEPS - 1)
                                            : dtc_pkg::STEP_W'(dtc_pkg::MUL_STEPS - 1);
        acc  <= '0;
        work <= a;
        rem  <= (cmd.op == dtc_pkg::OP_DIV) ? '0 : {1'b0, b};
        dvs  <= b;
      end else if (busy) begin
        if (op == dtc_pkg::OP_DIV) begin
          // remainder stays below the divisor, so trial fits in 37 bits
          rem  <= ge ? (trial - {1'b0, dvs}) : trial;
          acc  <= {acc[dtc_pkg::WORD_W-2:0], ge};
          work <= {work[dtc_pkg::WORD_W-2:0], 1'b0};
        end else begin
          if (rem[0]) begin
            acc <= acc + work;
          end
          work <= {work[dtc_pkg::WORD_W-2:0], 1'b0};
          rem  <= {1'b0, rem[dtc_pkg::RATE_W:1]};
        end
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign res      = acc;
  assign rmd      = rem[dtc_pkg::RATE_W-1:0];

endmodule

/* rtl/core/deadline_to_countdown_converter.sv */
// Deadline to one-shot countdown converter.
// Input stream (s_*): one item per request, tuser = mode (arm, disarm,
// expired), tdata = deadline in ns and the current timestamp count.
// Output stream (m_*): exactly one item per input item, tuser = action,
// tdata = countdown load value, current time in ns and the armed mark.
// Config: cfg_we/cfg_index/cfg_data write the stamp and countdown rates;
// write only while no item is in flight.
// Timing: every item runs one rescale (divide, two multiplies, divide) on a
// single shift/add unit at one bit per cycle. The next item can be taken once
// the result has moved to the output register. An arm that is not a repeat
// runs a second rescale. The 64-step divides dominate. s_tready is high only
// while the sequencer is idle, so one item is in work at a time.
// The result sits in an output register; a new item is taken while it waits.
// If the receiver stalls, a finished item waits in its last step until the
// output register frees up.
// Reset: synchronous; rates return to 1e9 Hz, armed mark cleared, no output
// item pending.
module deadline_to_countdown_converter (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // deadline[63:0], stamp_now[127:64]
  input  logic [1:0]   s_tuser,   // mode[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // load_count[31:0], now_ns[95:32], is_armed[96], zero pad
  output logic [1:0]   m_tuser,   // action[1:0]
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [35:0]  cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV1 = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_DIV2 = 3'd4;
  localparam logic [2:0] ST_NOW  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]                      state;
  logic                            pend;
  logic                            phase;
  logic                            go;
  logic [1:0]                      mode;
  logic [dtc_pkg::WORD_W-1:0]      deadline;
  logic [dtc_pkg::WORD_W-1:0]      vreg;
  logic [dtc_pkg::WORD_W-1:0]      qreg;
  logic [dtc_pkg::RATE_W-1:0]      rreg;
  logic [dtc_pkg::WORD_W-1:0]      sum;
  logic [dtc_pkg::WORD_W-1:0]      prod;
  logic [dtc_pkg::WORD_W-1:0]      now_reg;
  logic [dtc_pkg::RATE_W-1:0]      stamp_rate;
  logic [dtc_pkg::RATE_W-1:0]      countdown_rate;
  logic                            armed;
  logic [dtc_pkg::WORD_W-1:0]      armed_dl;

  logic [1:0]                      o_action;
  logic [dtc_pkg::COUNT_W-1:0]     o_load;
  logic [dtc_pkg::WORD_W-1:0]      o_now;
  logic                            o_armed;

  dtc_pkg::dtc_cmd_t               cmd;
  dtc_pkg::dtc_sts_t               sts;
  logic [dtc_pkg::WORD_W-1:0]      u_a;
  logic [dtc_pkg::RATE_W-1:0]      u_b;
  logic [dtc_pkg::WORD_W-1:0]      u_res;
  logic [dtc_pkg::RATE_W-1:0]      u_rmd;

  logic [dtc_pkg::RATE_W-1:0]      from_rate;
  logic [dtc_pkg::RATE_W-1:0]      to_rate;
  logic                            op_state;
  logic                            out_free;
  logic [dtc_pkg::COUNT_W-1:0]     clamped;

  logic [1:0]                      fin_action;
  logic [dtc_pkg::COUNT_W-1:0]     fin_load;
  logic                            fin_armed;

  dtc_unit u_unit (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .a   (u_a),
    .b   (u_b),
    .sts (sts),
    .res (u_res),
    .rmd (u_rmd)
  );

  // a zero stamp rate counts as 1 Hz
  always_comb begin
    if (phase) begin
      from_rate = dtc_pkg::NS_RATE;
      to_rate   = countdown_rate;
    end else begin
      from_rate = (stamp_rate == '0) ? dtc_pkg::RATE_W'(1) : stamp_rate;
      to_rate   = dtc_pkg::NS_RATE;
    end
  end

  assign op_state = (state == ST_DIV1) || (state == ST_MUL1) ||
                    (state == ST_MUL2) || (state == ST_DIV2);
  assign cmd.start = op_state && !pend && !sts.busy;
  assign cmd.op    = ((state == ST_MUL1) || (state == ST_MUL2)) ? dtc_pkg::OP_MUL
                                                                : dtc_pkg::OP_DIV;

  always_comb begin
    case (state)
      ST_DIV1: begin
        u_a = vreg;
        u_b = from_rate;
      end
      ST_MUL1: begin
        u_a = qreg;
        u_b = to_rate;
      end
      ST_MUL2: begin
        u_a = {{(dtc_pkg::WORD_W-dtc_pkg::RATE_W){1'b0}}, rreg};
        u_b = to_rate;
      end
      ST_DIV2: begin
        u_a = prod;
        u_b = from_rate;
      end
      default: begin
        u_a = vreg;
        u_b = from_rate;
      end
    endcase
  end

  always_comb begin
    if (sum == '0) begin
      clamped = dtc_pkg::COUNT_W'(1);
    end else if (sum > dtc_pkg::COUNT_MAX) begin
      clamped = dtc_pkg::COUNT_MAX[dtc_pkg::COUNT_W-1:0];
    end else begin
      clamped = sum[dtc_pkg::COUNT_W-1:0];
    end
  end

  // result fields and armed mark for the item in its last step
  always_comb begin
    fin_action = dtc_pkg::ACT_NONE;
    fin_load   = '0;
    fin_armed  = armed;
    case (mode)
      dtc_pkg::MODE_ARM: begin
        if (go) begin
          fin_action = dtc_pkg::ACT_LOAD;
          fin_load   = clamped;
          fin_armed  = 1'b1;
        end
      end
      dtc_pkg::MODE_DISARM: begin
        fin_action = dtc_pkg::ACT_STOP;
        fin_armed  = 1'b0;
      end
      dtc_pkg::MODE_EXPIRE: begin
        fin_armed = 1'b0;
      end
      default: ;
    endcase
  end

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      pend           <= 1'b0;
      m_tvalid       <= 1'b0;
      armed          <= 1'b0;
      armed_dl       <= '0;
      stamp_rate     <= dtc_pkg::NS_RATE;
      countdown_rate <= dtc_pkg::NS_RATE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dtc_pkg::REG_STAMP_RATE:     stamp_rate     <= cfg_data;
          dtc_pkg::REG_COUNTDOWN_RATE: countdown_rate <= cfg_data;
          default: ;
        endcase
      end

      if ((state == ST_FIN) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cmd.start) begin
        pend <= 1'b1;
      end else if (sts.done) begin
        pend <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            mode     <= s_tuser;
            deadline <= s_tdata[63:0];
            vreg     <= s_tdata[127:64];
            phase    <= 1'b0;
            state    <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (sts.done) begin
            qreg  <= u_res;
            rreg  <= u_rmd;
            state <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          if (sts.done) begin
            sum   <= u_res;
            state <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          if (sts.done) begin
            prod  <= u_res;
            state <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (sts.done) begin
            sum   <= sum + u_res;
            state <= phase ? ST_FIN : ST_NOW;
          end
        end
        ST_NOW: begin
          now_reg <= sum;
          // a repeated arm of the armed deadline loads nothing
          if (mode == dtc_pkg::MODE_ARM && !(armed && armed_dl == deadline)) begin
            go    <= 1'b1;
            vreg  <= (deadline > sum) ? (deadline - sum) : '0;
            phase <= 1'b1;
            state <= ST_DIV1;
          end else begin
            go    <= 1'b0;
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            o_now    <= now_reg;
            o_action <= fin_action;
            o_load   <= fin_load;
            o_armed  <= fin_armed;
            armed    <= fin_armed;
            if (mode == dtc_pkg::MODE_ARM && go) begin
              armed_dl <= deadline;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {7'd0, o_armed, o_now, o_load};
  assign m_tuser = o_action;

endmodule

/* test/tb_top.sv */
module tb_top;
  import dtc_pkg::*;

  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  localparam logic [1:0]  REG_SPARE    = 2'd2;
  localparam logic [1:0]  REG_SPARE_HI = 2'd3;
  localparam logic [35:0] RATE_TOP     = 36'hf_ffff_ffff;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_CYCLES = 500;
  localparam int CYCLE_LIMIT  = 3000000;

  typedef struct {
    logic [1:0]  mode;
    logic [63:0] deadline;
    logic [63:0] stamp;
  } timer_req_t;

  typedef struct {
    logic [1:0]  action;
    logic [31:0] load;
    logic [63:0] now_ns;
    logic        armed;
  } timer_res_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;   // deadline[63:0], stamp_now[127:64]
  logic [1:0]   s_tuser = '0;   // mode[1:0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;        // load_count[31:0], now_ns[95:32], is_armed[96]
  logic [1:0]   m_tuser;        // action[1:0]
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [35:0]  cfg_data = '0;

  // predictor state and configuration
  logic [35:0] stamp_rate = NS_RATE;
  logic [35:0] cd_rate    = NS_RATE;
  logic        armed_flag = 1'b0;
  logic [63:0] armed_dl   = '0;

  timer_req_t timer_req_q[$];
  timer_res_t countdown_exp[$];
  timer_req_t in_flight;
  timer_res_t want;
  logic [63:0] last_deadline = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int err_count      = 0;
  int cycle_count    = 0;
  int hold_left      = 0;
  logic hold_req     = 1'b0;

  deadline_to_countdown_converter uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // quotient plus remainder scaling, all products wrap at 64 bits
  function automatic logic [63:0] rescale64(logic [63:0] v, logic [63:0] from,
                                            logic [63:0] to);
    logic [63:0] f;
    logic [63:0] q;
    logic [63:0] r;
    f = (from == 64'd0) ? 64'd1 : from;
    q = v / f;
    r = v - q * f;
    return q * to + (r * to) / f;
  endfunction

  function automatic timer_res_t predict_countdown(timer_req_t rq);
    timer_res_t rs;
    logic [63:0] delta;
    logic [63:0] count;
    rs.action = ACT_NONE;
    rs.load   = '0;
    rs.now_ns = rescale64(rq.stamp, 64'(stamp_rate), 64'(NS_RATE));
    case (rq.mode)
      MODE_ARM: begin
        if (!(armed_flag && armed_dl == rq.deadline)) begin
          delta = (rq.deadline > rs.now_ns) ? rq.deadline - rs.now_ns : 64'd0;
          count = rescale64(delta, 64'(NS_RATE), 64'(cd_rate));
          if (count == 64'd0) count = 64'd1;
          if (count > COUNT_MAX) count = COUNT_MAX;
          armed_dl   = rq.deadline;
          armed_flag = 1'b1;
          rs.action  = ACT_LOAD;
          rs.load    = count[31:0];
        end
      end
      MODE_DISARM: begin
        armed_flag = 1'b0;
        rs.action  = ACT_STOP;
      end
      MODE_EXPIRE: armed_flag = 1'b0;
      default: ;
    endcase
    rs.armed = armed_flag;
    return rs;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [35:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_STAMP_RATE) stamp_rate = val;
    else if (idx == REG_COUNTDOWN_RATE) cd_rate = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_item(logic [1:0] mode, logic [63:0] deadline, logic [63:0] stamp);
    timer_req_t rq;
    rq.mode     = mode;
    rq.deadline = deadline;
    rq.stamp    = stamp;
    timer_req_q.push_back(rq);
  endtask

  // mostly arms near the current time, with repeats, disarms, expiries and noise
  task automatic add_random_item();
    timer_req_t rq;
    int pick;
    int sel;
    logic [63:0] now;
    pick = $urandom_range(99);
    sel  = $urandom_range(9);
    rq.stamp = ($urandom_range(9) < 4) ? rand64() : rand64() >> $urandom_range(63);
    now = rescale64(rq.stamp, 64'(stamp_rate), 64'(NS_RATE));
    rq.deadline = rand64();
    if (pick < 50) begin
      rq.mode = MODE_ARM;
      if (sel == 1 || sel == 2) rq.deadline = now - (rand64() >> $urandom_range(63, 20));
      else if (sel > 2) rq.deadline = now + (rand64() >> $urandom_range(63, 8));
      last_deadline = rq.deadline;
    end else if (pick < 65) begin
      rq.mode     = MODE_ARM;
      rq.deadline = last_deadline;
    end else if (pick < 80) begin
      rq.mode = MODE_DISARM;
    end else if (pick < 95) begin
      rq.mode = MODE_EXPIRE;
    end else begin
      rq.mode = MODE_UNUSED;
    end
    timer_req_q.push_back(rq);
  endtask

  // checked between edges, once every update of the edge has settled
  task automatic wait_drained();
    @(negedge clk);
    while (timer_req_q.size() != 0 || s_tvalid || countdown_exp.size() != 0)
      @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) countdown_exp.push_back(predict_countdown(in_flight));
      if (!s_tvalid || s_tready) begin
        if (timer_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = timer_req_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= in_flight.mode;
          s_tdata  <= {in_flight.stamp, in_flight.deadline};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (countdown_exp.size() == 0) begin
          $display("%0t: unexpected item: expected none, got action %h data %h",
                   $time, m_tuser, m_tdata);
          err_count++;
        end else begin
          want = countdown_exp.pop_front();
          if (m_tuser !== want.action) begin
            $display("%0t: action: expected %h, got %h", $time, want.action, m_tuser);
            err_count++;
          end
          if (m_tdata[31:0] !== want.load) begin
            $display("%0t: load_count: expected %h, got %h", $time, want.load,
                     m_tdata[31:0]);
            err_count++;
          end
          if (m_tdata[95:32] !== want.now_ns) begin
            $display("%0t: now_ns: expected %h, got %h", $time, want.now_ns,
                     m_tdata[95:32]);
            err_count++;
          end
          if (m_tdata[96] !== want.armed) begin
            $display("%0t: is_armed: expected %h, got %h", $time, want.armed,
                     m_tdata[96]);
            err_count++;
          end
        end
      end
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset rates: now_ns equals the stamp, count equals the time left
    add_item(MODE_UNUSED, 64'd0, 64'd0);
    add_item(MODE_ARM, 64'd1000, 64'd0);
    add_item(MODE_ARM, 64'd1000, 64'd500);          // repeat of armed deadline
    add_item(MODE_UNUSED, 64'd7, 64'd9);            // ignored, stays armed
    add_item(MODE_ARM, 64'd0, 64'd100);             // deadline passed
    add_item(MODE_EXPIRE, 64'd0, 64'd200);
    add_item(MODE_ARM, 64'd2000, 64'd2000);         // zero time left
    add_item(MODE_DISARM, 64'd0, 64'd2500);
    add_item(MODE_DISARM, '1, '1);                  // disarm while idle
    add_item(MODE_ARM, '1, 64'd0);                  // count saturates
    add_item(MODE_ARM, '1, 64'd1);
    add_item(MODE_ARM, 64'd5, '1);
    add_item(MODE_ARM, 64'h1_0000_0000, 64'd0);
    add_item(MODE_ARM, 64'hffff_ffff, 64'd0);
    add_item(MODE_EXPIRE, '1, '1);
    wait_drained();

    write_reg(REG_STAMP_RATE, 36'd0);
    write_reg(REG_COUNTDOWN_RATE, 36'd0);
    // spare indexes must be ignored
    write_reg(REG_SPARE, RATE_TOP);
    write_reg(REG_SPARE_HI, RATE_TOP);
    @(negedge clk);
    add_item(MODE_ARM, '1, 64'd3);                  // zero countdown rate
    add_item(MODE_ARM, 64'd10, 64'd0);
    add_item(MODE_UNUSED, 64'd0, '1);
    wait_drained();

    write_reg(REG_STAMP_RATE, RATE_TOP);
    write_reg(REG_COUNTDOWN_RATE, RATE_TOP);
    write_reg(REG_SPARE, 36'd1);
    write_reg(REG_SPARE_HI, 36'd0);
    @(negedge clk);
    add_item(MODE_ARM, 64'd2_000_000_000, {28'd0, RATE_TOP});
    add_item(MODE_ARM, 64'd1_000_000_001, {28'd0, RATE_TOP});
    add_item(MODE_DISARM, 64'd0, '1);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      case (p)
        0: begin write_reg(REG_STAMP_RATE, NS_RATE); write_reg(REG_COUNTDOWN_RATE, NS_RATE); end
        1: begin write_reg(REG_STAMP_RATE, RATE_TOP); write_reg(REG_COUNTDOWN_RATE, RATE_TOP); end
        2: begin write_reg(REG_STAMP_RATE, 36'd1); write_reg(REG_COUNTDOWN_RATE, 36'd1); end
        3: begin write_reg(REG_STAMP_RATE, 36'd0); write_reg(REG_COUNTDOWN_RATE, 36'd0); end
        4: begin
          write_reg(REG_STAMP_RATE, 36'd2_900_000_000);
          write_reg(REG_COUNTDOWN_RATE, 36'd24_000_000);
        end
        5: begin
          write_reg(REG_STAMP_RATE, 36'd19_200_000);
          write_reg(REG_COUNTDOWN_RATE, NS_RATE);
        end
        default: begin
          write_reg(REG_STAMP_RATE, {4'($urandom_range(15)), $urandom});
          write_reg(REG_COUNTDOWN_RATE, {4'($urandom_range(15)), $urandom});
        end
      endcase
      @(negedge clk);
      repeat (105) add_random_item();
      if (p == 0) begin
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* deadline_to_countdown_converter.f */
rtl/core/dtc_pkg.sv
rtl/core/dtc_unit.sv
rtl/core/deadline_to_countdown_converter.sv
test/tb_top.sv
